[rtl/core/tms_pkg.sv]
// Shared constants, types and reset values for the triangle midpoint subdivider.
`default_nettype none

package tms_pkg;

   localparam int MAX_LEVEL   = 10;
   localparam int COORD_BITS  = 16;
   localparam int LEVEL_W     = $clog2(MAX_LEVEL + 1);
   localparam int LEVEL_CFG_W = 4;
   localparam int INDEX_W     = 20;
   localparam int DIGITS_W    = 2 * MAX_LEVEL;
   localparam int NUM_VERTS   = 3;
   localparam int NUM_COORDS  = 2 * NUM_VERTS;

   // texture mapping: Q0.16 results from a restoring divide by a small constant
   localparam int TEX_W      = 16;
   localparam int TEX_NUM_W  = COORD_BITS + 6;
   localparam int TEX_DVD_W  = TEX_NUM_W - 1;
   localparam int TEX_DIV_W  = 4;
   localparam int CNT_W      = $clog2(TEX_DVD_W);

   localparam logic [TEX_NUM_W-1:0] TEX_U_BIAS    = TEX_NUM_W'(425990);
   localparam logic [TEX_NUM_W-1:0] TEX_V_BIAS    = TEX_NUM_W'(196612);
   localparam logic [TEX_DIV_W-1:0] TEX_U_DIVISOR = TEX_DIV_W'(13);
   localparam logic [TEX_DIV_W-1:0] TEX_V_DIVISOR = TEX_DIV_W'(9);
   localparam logic [TEX_W-1:0]     TEX_MAX       = '1;

   // stream widths, padded to whole bytes
   localparam int REQ_W = ((INDEX_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = NUM_COORDS * COORD_BITS + NUM_COORDS * TEX_W;
   localparam int RSP_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_ADDR_W-3:0] reg_index_type;

   localparam reg_index_type REG_LEVEL  = reg_index_type'(0);
   localparam reg_index_type REG_A_X    = reg_index_type'(1);
   localparam reg_index_type REG_A_Y    = reg_index_type'(2);
   localparam reg_index_type REG_B_X    = reg_index_type'(3);
   localparam reg_index_type REG_B_Y    = reg_index_type'(4);
   localparam reg_index_type REG_C_X    = reg_index_type'(5);
   localparam reg_index_type REG_C_Y    = reg_index_type'(6);

   typedef enum logic [1:0] {
      CHILD_A   = 2'd0,
      CHILD_B   = 2'd1,
      CHILD_C   = 2'd2,
      CHILD_MID = 2'd3
   } child_type;

   typedef struct packed {
      logic [LEVEL_CFG_W-1:0]                 level;
      logic [NUM_VERTS-1:0][COORD_BITS-1:0]   base_x;
      logic [NUM_VERTS-1:0][COORD_BITS-1:0]   base_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      level:  '0,
      base_x: {COORD_BITS'(-10650), COORD_BITS'(10650), COORD_BITS'(0)},
      base_y: {COORD_BITS'(-6144), COORD_BITS'(-6144), COORD_BITS'(12288)}
   };

   typedef struct packed {
      logic      load;
      logic      shift;
      logic      first_bit;
      logic      last_bit;
      child_type digit;
   } sub_ctrl_type;

   typedef struct packed {
      logic load;
      logic shift;
   } tex_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/triangle_midpoint_subdivider.sv]
// Top level: request/response streams, level sequencer, subdivision and texture units.
//
// Usage: a request carries a leaf index; the block walks its base-4 digits from the top
// level down, one subdivision level at a time, and returns the leaf's three vertices
// (signed Q1.14) and their texture coordinates (Q0.16) as one response.
// Each level runs bit-serially through the six vertex shift registers, COORD_BITS (16)
// bits a level. The texture step is a restoring divide, one quotient bit a cycle, over
// TEX_DVD_W (21) bits, after a load step. One request is in work at a time; the next
// can be taken in the cycle after the result moves to the output register.
// The output register holds one response; a new request is accepted while it waits.
// If the receiver stalls and a second result is finished, the block holds it and takes
// no request until the output register frees up.
// Reset (synchronous) empties the block and restores the default base triangle at level 0.
// The user must write registers only while no request is in work; the block does not check.
`default_nettype none

module triangle_midpoint_subdivider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: [19:0] leaf_index
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [tms_pkg::REQ_W-1:0]        req_tdata,
   // response: first_x, first_y, second_x, second_y, third_x, third_y,
   //           first_u, first_v, second_u, second_v, third_u, third_v (16 bits each)
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [tms_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [tms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [tms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [tms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUBDIV,
      ST_TEX_LOAD,
      ST_TEX,
      ST_FINISH
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   logic [tms_pkg::CNT_W-1:0]          cnt_ff;
   logic [tms_pkg::CNT_W-1:0]          cnt_in;
   logic [tms_pkg::LEVEL_W-1:0]        levels_ff;
   logic [tms_pkg::LEVEL_W-1:0]        levels_in;
   logic [tms_pkg::DIGITS_W-1:0]       digits_ff;
   logic [tms_pkg::DIGITS_W-1:0]       digits_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [tms_pkg::RSP_W-1:0]          rsp_data_ff;
   logic [tms_pkg::RSP_W-1:0]          rsp_data_in;

   tms_pkg::cfg_type                   cfg;
   tms_pkg::sub_ctrl_type              sub_ctrl;
   tms_pkg::tex_ctrl_type              tex_ctrl;
   logic [tms_pkg::NUM_COORDS-1:0][tms_pkg::COORD_BITS-1:0] coord;
   logic [tms_pkg::NUM_COORDS-1:0][tms_pkg::TEX_W-1:0]      tex;

   logic                               req_accept;
   logic                               bit_last;
   logic [tms_pkg::LEVEL_W-1:0]        lvl_sat;
   logic [tms_pkg::LEVEL_W:0]          digit_shamt;
   logic [tms_pkg::INDEX_W+tms_pkg::DIGITS_W-1:0] index_wide;

   tms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   tms_subdiv u_subdiv (
      .clock (clock),
      .ctrl  (sub_ctrl),
      .cfg   (cfg),
      .coord (coord)
   );

   for (genvar c = 0; c < tms_pkg::NUM_COORDS; c++) begin : g_tex
      tms_tex_div u_tex (
         .clock (clock),
         .ctrl  (tex_ctrl),
         .is_v  (c % 2 == 1),
         .coord (coord[c]),
         .tex   (tex[c])
      );
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign bit_last   = (cnt_ff == tms_pkg::CNT_W'(tms_pkg::COORD_BITS - 1));

   always_comb begin
      if (32'(cfg.level) > tms_pkg::MAX_LEVEL) begin
         lvl_sat = tms_pkg::LEVEL_W'(tms_pkg::MAX_LEVEL);
      end else begin
         lvl_sat = tms_pkg::LEVEL_W'(cfg.level);
      end
      // align the top-level digit to the MSB pair; index bits at and above 2*level drop out
      digit_shamt = {tms_pkg::LEVEL_W'(tms_pkg::MAX_LEVEL) - lvl_sat, 1'b0};
      index_wide  = {tms_pkg::DIGITS_W'(0), req_tdata[tms_pkg::INDEX_W-1:0]} << digit_shamt;
   end

   always_comb begin
      sub_ctrl.load      = req_accept;
      sub_ctrl.shift     = (state_ff == ST_SUBDIV);
      sub_ctrl.first_bit = (cnt_ff == '0);
      sub_ctrl.last_bit  = bit_last;
      sub_ctrl.digit     = tms_pkg::child_type'(digits_ff[tms_pkg::DIGITS_W-1 -: 2]);
      tex_ctrl.load      = (state_ff == ST_TEX_LOAD);
      tex_ctrl.shift     = (state_ff == ST_TEX);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      levels_in    = levels_ff;
      digits_in    = digits_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cnt_in    = '0;
               levels_in = lvl_sat;
               digits_in = index_wide[tms_pkg::DIGITS_W-1:0];
               state_in  = (lvl_sat == '0) ? ST_TEX_LOAD : ST_SUBDIV;
            end
         end
         ST_SUBDIV: begin
            cnt_in = tms_pkg::CNT_W'(cnt_ff + 1'b1);
            if (bit_last) begin
               cnt_in    = '0;
               levels_in = tms_pkg::LEVEL_W'(levels_ff - 1'b1);
               digits_in = digits_ff << 2;
               if (levels_ff == tms_pkg::LEVEL_W'(1)) begin
                  state_in = ST_TEX_LOAD;
               end
            end
         end
         ST_TEX_LOAD: begin
            cnt_in   = '0;
            state_in = ST_TEX;
         end
         ST_TEX: begin
            cnt_in = tms_pkg::CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == tms_pkg::CNT_W'(tms_pkg::TEX_DVD_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tms_pkg::RSP_W'({tex, coord});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         levels_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         levels_ff    <= levels_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_subdiv_has_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUBDIV |-> levels_ff != '0)
      else $error("subdivision running with no level left");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready)
         |=> (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("finished result dropped while output register was full");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside of finish state");

   a_tex_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEX |-> cnt_ff < tms_pkg::CNT_W'(tms_pkg::TEX_DVD_W))
      else $error("texture divide ran past its quotient width");

endmodule

`default_nettype wire

[rtl/core/tms_csr.sv]
// Configuration registers behind the APB-style port.
`default_nettype none

module tms_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [tms_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [tms_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [tms_pkg::CSR_DATA_W-1:0]   prdata,
   output tms_pkg::cfg_type                      cfg
);

   tms_pkg::cfg_type       cfg_ff;
   tms_pkg::cfg_type       cfg_in;
   tms_pkg::reg_index_type reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[tms_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tms_pkg::REG_LEVEL: cfg_in.level = pwdata[tms_pkg::LEVEL_CFG_W-1:0];
            tms_pkg::REG_A_X:   cfg_in.base_x[0] = pwdata[tms_pkg::COORD_BITS-1:0];
            tms_pkg::REG_A_Y:   cfg_in.base_y[0] = pwdata[tms_pkg::COORD_BITS-1:0];
            tms_pkg::REG_B_X:   cfg_in.base_x[1] = pwdata[tms_pkg::COORD_BITS-1:0];
            tms_pkg::REG_B_Y:   cfg_in.base_y[1] = pwdata[tms_pkg::COORD_BITS-1:0];
            tms_pkg::REG_C_X:   cfg_in.base_x[2] = pwdata[tms_pkg::COORD_BITS-1:0];
            tms_pkg::REG_C_Y:   cfg_in.base_y[2] = pwdata[tms_pkg::COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tms_pkg::REG_LEVEL: prdata = tms_pkg::CSR_DATA_W'(cfg_ff.level);
         tms_pkg::REG_A_X:   prdata = tms_pkg::CSR_DATA_W'(cfg_ff.base_x[0]);
         tms_pkg::REG_A_Y:   prdata = tms_pkg::CSR_DATA_W'(cfg_ff.base_y[0]);
         tms_pkg::REG_B_X:   prdata = tms_pkg::CSR_DATA_W'(cfg_ff.base_x[1]);
         tms_pkg::REG_B_Y:   prdata = tms_pkg::CSR_DATA_W'(cfg_ff.base_y[1]);
         tms_pkg::REG_C_X:   prdata = tms_pkg::CSR_DATA_W'(cfg_ff.base_x[2]);
         tms_pkg::REG_C_Y:   prdata = tms_pkg::CSR_DATA_W'(cfg_ff.base_y[2]);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tms_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/tms_subdiv.sv]
// Bit-serial midpoint subdivision: six vertex coordinate shift registers, LSB first.
`default_nettype none

module tms_subdiv (
   input  wire logic                  clock,
   input  wire tms_pkg::sub_ctrl_type ctrl,
   input  wire tms_pkg::cfg_type      cfg,
   output logic [tms_pkg::NUM_COORDS-1:0][tms_pkg::COORD_BITS-1:0] coord
);

   // coordinate c belongs to vertex c/2, axis c%2 (0 = x, 1 = y)
   logic [tms_pkg::COORD_BITS-1:0] pos_ff [tms_pkg::NUM_COORDS];
   logic [tms_pkg::COORD_BITS-1:0] pos_in [tms_pkg::NUM_COORDS];
   // serial adder carries per axis, per pair (ab, bc, ac)
   logic [2:0] carry_ff [2];
   logic [2:0] carry_in [2];

   // floor((p+q)/2) = (p>>>1) + (q>>>1) + (p0 & q0): at bit j use bit j+1 of each
   // operand (sign bit on the last bit), seeding the carry with p0 & q0.
   always_comb begin
      logic [2:0] lo_bit;
      logic [2:0] hi_bit;
      logic [2:0] cin;
      logic [2:0] mid_bit;
      logic [2:0] new_bit;
      logic [tms_pkg::COORD_BITS-1:0] base;
      lo_bit  = '0;
      hi_bit  = '0;
      cin     = '0;
      mid_bit = '0;
      new_bit = '0;
      base    = '0;
      for (int a = 0; a < 2; a++) begin
         for (int v = 0; v < tms_pkg::NUM_VERTS; v++) begin
            lo_bit[v] = pos_ff[2*v+a][0];
            hi_bit[v] = ctrl.last_bit ? pos_ff[2*v+a][0] : pos_ff[2*v+a][1];
         end
         cin[0] = ctrl.first_bit ? (lo_bit[0] & lo_bit[1]) : carry_ff[a][0];
         cin[1] = ctrl.first_bit ? (lo_bit[1] & lo_bit[2]) : carry_ff[a][1];
         cin[2] = ctrl.first_bit ? (lo_bit[0] & lo_bit[2]) : carry_ff[a][2];
         mid_bit[0] = hi_bit[0] ^ hi_bit[1] ^ cin[0];
         mid_bit[1] = hi_bit[1] ^ hi_bit[2] ^ cin[1];
         mid_bit[2] = hi_bit[0] ^ hi_bit[2] ^ cin[2];
         carry_in[a][0] = (hi_bit[0] & hi_bit[1]) | (cin[0] & (hi_bit[0] ^ hi_bit[1]));
         carry_in[a][1] = (hi_bit[1] & hi_bit[2]) | (cin[1] & (hi_bit[1] ^ hi_bit[2]));
         carry_in[a][2] = (hi_bit[0] & hi_bit[2]) | (cin[2] & (hi_bit[0] ^ hi_bit[2]));

         unique case (ctrl.digit)
            tms_pkg::CHILD_A:   new_bit = {mid_bit[2], mid_bit[0], lo_bit[0]};
            tms_pkg::CHILD_B:   new_bit = {mid_bit[0], mid_bit[1], lo_bit[1]};
            tms_pkg::CHILD_C:   new_bit = {mid_bit[1], mid_bit[2], lo_bit[2]};
            tms_pkg::CHILD_MID: new_bit = {mid_bit[1], mid_bit[2], mid_bit[0]};
            default:            new_bit = '0;
         endcase

         for (int v = 0; v < tms_pkg::NUM_VERTS; v++) begin
            base = (a == 0) ? cfg.base_x[v] : cfg.base_y[v];
            if (ctrl.load) begin
               pos_in[2*v+a] = base;
            end else if (ctrl.shift) begin
               pos_in[2*v+a] = {new_bit[v], pos_ff[2*v+a][tms_pkg::COORD_BITS-1:1]};
            end else begin
               pos_in[2*v+a] = pos_ff[2*v+a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      carry_ff <= carry_in;
   end

   always_comb begin
      for (int c = 0; c < tms_pkg::NUM_COORDS; c++) begin
         coord[c] = pos_ff[c];
      end
   end

endmodule

`default_nettype wire

[rtl/core/tms_tex_div.sv]
// Texture coordinate unit: affine numerator, then a one-bit-per-cycle restoring divide.
`default_nettype none

module tms_tex_div (
   input  wire logic                             clock,
   input  wire tms_pkg::tex_ctrl_type            ctrl,
   input  wire logic                             is_v,
   input  wire logic [tms_pkg::COORD_BITS-1:0]   coord,
   output logic      [tms_pkg::TEX_W-1:0]        tex
);

   logic                              neg_ff;
   logic                              neg_in;
   // dividend shifts out the top while quotient bits shift in at the bottom
   logic [tms_pkg::TEX_DVD_W-1:0]     dq_ff;
   logic [tms_pkg::TEX_DVD_W-1:0]     dq_in;
   logic [tms_pkg::TEX_DIV_W-1:0]     rem_ff;
   logic [tms_pkg::TEX_DIV_W-1:0]     rem_in;

   always_comb begin
      logic [tms_pkg::TEX_NUM_W-1:0] c_ext;
      logic [tms_pkg::TEX_NUM_W-1:0] num;
      logic [tms_pkg::TEX_DIV_W-1:0] divisor;
      logic [tms_pkg::TEX_DIV_W:0]   trial;
      c_ext = tms_pkg::TEX_NUM_W'(signed'(coord));
      if (is_v) begin
         // 32*(y + 6144) + 4
         num     = (c_ext << 5) + tms_pkg::TEX_V_BIAS;
         divisor = tms_pkg::TEX_V_DIVISOR;
      end else begin
         // 40*x + 425984 + 6
         num     = (c_ext << 5) + (c_ext << 3) + tms_pkg::TEX_U_BIAS;
         divisor = tms_pkg::TEX_U_DIVISOR;
      end
      trial  = {rem_ff, dq_ff[tms_pkg::TEX_DVD_W-1]};
      neg_in = neg_ff;
      dq_in  = dq_ff;
      rem_in = rem_ff;
      if (ctrl.load) begin
         neg_in = num[tms_pkg::TEX_NUM_W-1];
         dq_in  = num[tms_pkg::TEX_DVD_W-1:0];
         rem_in = '0;
      end else if (ctrl.shift) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = tms_pkg::TEX_DIV_W'(trial - {1'b0, divisor});
            dq_in  = {dq_ff[tms_pkg::TEX_DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[tms_pkg::TEX_DIV_W-1:0];
            dq_in  = {dq_ff[tms_pkg::TEX_DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      if (neg_ff) begin
         tex = '0;
      end else if (dq_ff > tms_pkg::TEX_DVD_W'(tms_pkg::TEX_MAX)) begin
         tex = tms_pkg::TEX_MAX;
      end else begin
         tex = tms_pkg::TEX_W'(dq_ff);
      end
   end

endmodule

`default_nettype wire
